### hw/rtl/rv64_subset_instruction_step_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RV64 subset step core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RV64_SUBSET_INSTRUCTION_STEP_TOP_DEFINES_SVH
`define RV64_SUBSET_INSTRUCTION_STEP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RVS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define RVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define RVS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define RVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### hw/rtl/rvs_pkg.sv
// ----------------------------------------------------------------------------
// RV64 subset step core package
// Request and result types, operation codes and shared unit codes.
// ----------------------------------------------------------------------------
package rvs_pkg;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] load_address;
        logic [7:0]  load_data;
    } in_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        reg_written;
        logic [4:0]  dest_index;
        logic [63:0] dest_value;
        logic        halted;
        logic        unknown_instr;
    } out_t;

    typedef enum logic [1:0] {
        MD_MUL,
        MD_MULH,
        MD_DIV,
        MD_REM
    } md_kind_t;

    localparam logic [1:0] OP_LOAD_BYTE = 2'd0;
    localparam logic [1:0] OP_EXEC      = 2'd1;
    localparam logic [1:0] OP_START     = 2'd2;

    localparam logic [1:0] CFG_ENTRY_PC  = 2'd0;
    localparam logic [1:0] CFG_END_PC    = 2'd1;
    localparam logic [1:0] CFG_STACK     = 2'd2;
    localparam logic [1:0] CFG_GLOBAL_PTR = 2'd3;

    localparam logic [6:0] OPC_OP     = 7'd51;
    localparam logic [6:0] OPC_OP32   = 7'd59;
    localparam logic [6:0] OPC_IMM    = 7'd19;
    localparam logic [6:0] OPC_IMM32  = 7'd27;
    localparam logic [6:0] OPC_STORE  = 7'd35;
    localparam logic [6:0] OPC_LOAD   = 7'd3;
    localparam logic [6:0] OPC_BRANCH = 7'd99;
    localparam logic [6:0] OPC_JALR   = 7'd103;
    localparam logic [6:0] OPC_JAL    = 7'd111;
    localparam logic [6:0] OPC_AUIPC  = 7'd23;
    localparam logic [6:0] OPC_LUI    = 7'd55;

    localparam logic [6:0] F7_BASE   = 7'd0;
    localparam logic [6:0] F7_ALT    = 7'd32;
    localparam logic [6:0] F7_MULDIV = 7'd1;
    localparam logic [5:0] F6_BASE   = 6'd0;
    localparam logic [5:0] F6_SRA    = 6'd16;

endpackage

### hw/rtl/rvs_bytemem.sv
// ----------------------------------------------------------------------------
// Byte memory
// Program and data storage, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rvs_bytemem #(
    parameter int MEM_BYTES = 65536
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [$clog2(MEM_BYTES)-1:0] waddr,
    input  logic [7:0]                   wdata,
    input  logic [$clog2(MEM_BYTES)-1:0] raddr,
    output logic [7:0]                   rdata
);
    logic [7:0] mem [MEM_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### hw/rtl/rvs_regfile.sv
// ----------------------------------------------------------------------------
// Integer register file
// 32 x 64 bits, one write and one registered read; unwritten entries read 0.
// ----------------------------------------------------------------------------
module rvs_regfile (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [63:0] wdata,
    input  logic [4:0]  raddr,
    output logic [63:0] rdata
);
    logic [63:0] mem [32];
    logic [31:0] valid_reg;
    logic [63:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : 64'd0;
    end

    assign rdata = rdata_reg;
endmodule

### hw/rtl/rvs_muldiv.sv
// ----------------------------------------------------------------------------
// Iterative multiply and divide unit
// Sign-magnitude shift-add multiply and restoring divide, one bit a cycle.
// ----------------------------------------------------------------------------
module rvs_muldiv (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  rvs_pkg::md_kind_t kind,
    input  logic [63:0]       op_a,
    input  logic [63:0]       op_b,
    output logic              done,
    output logic [63:0]       result
);
    import rvs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX
    } state_t;

    state_t      state_reg;
    md_kind_t    kind_reg;
    logic [63:0] hi_reg, lo_reg, mb_reg, a_reg;
    logic        neg_a_reg, neg_b_reg, bzero_reg;
    logic [5:0]  cnt_reg;

    logic [64:0]  msum;
    logic [64:0]  r2;
    logic [65:0]  diff;
    logic         ge;
    logic         sgn;
    logic [127:0] prod, prod_s;

    always_comb begin
        msum   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mb_reg} : 65'd0);
        r2     = {hi_reg, lo_reg[63]};
        diff   = {1'b0, r2} - {2'b00, mb_reg};
        ge     = !diff[65];
        sgn    = neg_a_reg ^ neg_b_reg;
        prod   = {hi_reg, lo_reg};
        prod_s = sgn ? (128'd0 - prod) : prod;
        unique case (kind_reg)
            MD_MUL:  result = prod_s[63:0];
            MD_MULH: result = prod_s[127:64];
            MD_DIV:  result = bzero_reg ? {64{1'b1}} : (sgn ? (64'd0 - lo_reg) : lo_reg);
            MD_REM:  result = bzero_reg ? a_reg : (neg_a_reg ? (64'd0 - hi_reg) : hi_reg);
            default: result = 64'd0;
        endcase
    end

    assign done = (state_reg == S_FIX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        kind_reg  <= kind;
                        a_reg     <= op_a;
                        neg_a_reg <= op_a[63];
                        neg_b_reg <= op_b[63];
                        bzero_reg <= (op_b == 64'd0);
                        hi_reg    <= 64'd0;
                        lo_reg    <= op_a[63] ? (64'd0 - op_a) : op_a;
                        mb_reg    <= op_b[63] ? (64'd0 - op_b) : op_b;
                        cnt_reg   <= 6'd63;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (kind_reg == MD_MUL || kind_reg == MD_MULH) begin
                        hi_reg <= msum[64:1];
                        lo_reg <= {msum[0], lo_reg[63:1]};
                    end else begin
                        hi_reg <= ge ? diff[63:0] : r2[63:0];
                        lo_reg <= {lo_reg[62:0], ge};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0) begin
                        state_reg <= S_FIX;
                    end
                end
                S_FIX: begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/rv64_subset_instruction_step_top.sv
// ----------------------------------------------------------------------------
// RV64 subset instruction step core
// Loads a byte memory, starts a program and executes one instruction a request.
// ----------------------------------------------------------------------------
// Each request on s_ (valid/ready) is one op: load a memory byte, start, or
// execute one instruction; it produces exactly one result on m_ (valid/ready).
// The config port (cfg_we, cfg_index, cfg_wdata) sets entry pc, end pc and the
// initial sp and gp; write it only while the core is idle.
// Load byte and halted steps go straight to the result; start also writes sp and
// gp. An executed instruction fetches its 4 bytes one byte at a time and reads two
// registers over one register file port; a load or store then moves its n bytes
// one at a time, and mul, mulh, mulw, div and rem run one bit a cycle in the
// shared multiply/divide unit.
// One request is in flight at a time; s_ready is high only when the core waits
// for work, even while an earlier result still sits in the output register.
// If the receiver stalls, the finished result waits and the core holds.
// Reset clears pc, halt flag and the register file (valid bits) at once;
// memory contents are undefined until loaded. MEM_BYTES must be a power of two.
// ----------------------------------------------------------------------------
`include "rv64_subset_instruction_step_top_defines.svh"

module rv64_subset_instruction_step_top #(
    parameter int MEM_BYTES = 65536
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rvs_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rvs_pkg::out_t m_data,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_wdata
);
    import rvs_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_XOR = 3'd4;
    localparam logic [2:0] F3_SR  = 3'd5, F3_OR  = 3'd6, F3_AND = 3'd7;
    localparam logic [2:0] F3_MUL = 3'd0, F3_MULH = 3'd1, F3_DIV = 3'd4, F3_REM = 3'd6;
    localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
    localparam logic [4:0] REG_SP = 5'd2, REG_GP = 5'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_START_SP, S_START_GP, S_MEMRD, S_RS1, S_RS2, S_RS3,
        S_EXEC, S_MULDIV, S_LDEXT, S_MEMWR, S_WB, S_FIN
    } state_t;

    function automatic logic [63:0] sext32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    state_t      state_reg;
    logic [15:0] entry_pc_reg, end_pc_reg, stack_reg, gp_reg;
    logic [15:0] pc_reg, npc_reg;
    logic        halt_reg;
    logic [31:0] inst_reg;
    logic [63:0] a_reg, b_reg, res_reg, data_reg;
    logic [AW-1:0] base_reg;
    logic [3:0]  n_reg, issue_reg, cap_reg;
    logic        pend_reg, fetch_reg, wr_reg, bad_reg, word_reg;
    out_t        stage_reg, m_data_reg;
    logic        m_valid_reg;

    logic          accept;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;
    logic          rf_we;
    logic [4:0]    rf_waddr, rf_raddr;
    logic [63:0]   rf_wdata, rf_rdata;
    logic          md_start, md_done;
    logic [63:0]   md_result;
    logic [63:0]   pc_ext, ld_ext;

    // Decode and ALU results for the instruction in inst_reg.
    logic [6:0]  opc, f7;
    logic [5:0]  f6;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [63:0] immi, imms, immb, immj, immu, opb, sum, dif, ea;
    logic [15:0] pc4;
    logic        take;
    logic [63:0] d_res;
    logic [15:0] d_npc;
    logic        d_wr, d_bad, d_md, d_word, d_load, d_store;
    md_kind_t    d_kind;
    logic [63:0] ld_val;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;
    assign pc_ext = {48'd0, pc_reg};
    assign ld_ext = {48'd0, s_data.load_address};

    always_comb begin
        opc  = inst_reg[6:0];
        rd   = inst_reg[11:7];
        f3   = inst_reg[14:12];
        f7   = inst_reg[31:25];
        f6   = inst_reg[31:26];
        immi = {{52{inst_reg[31]}}, inst_reg[31:20]};
        imms = {{52{inst_reg[31]}}, inst_reg[31:25], inst_reg[11:7]};
        immb = {{51{inst_reg[31]}}, inst_reg[31], inst_reg[7], inst_reg[30:25],
                inst_reg[11:8], 1'b0};
        immj = {{43{inst_reg[31]}}, inst_reg[31], inst_reg[19:12], inst_reg[20],
                inst_reg[30:21], 1'b0};
        immu = {{32{inst_reg[31]}}, inst_reg[31:12], 12'd0};
        opb  = (opc == OPC_OP || opc == OPC_OP32) ? b_reg : immi;
        sum  = a_reg + opb;
        dif  = a_reg - opb;
        pc4  = pc_reg + 16'd4;
        ea   = a_reg + immi;
        take = 1'b0;

        d_res   = 64'd0;
        d_npc   = pc4;
        d_wr    = 1'b0;
        d_bad   = 1'b0;
        d_md    = 1'b0;
        d_word  = 1'b0;
        d_load  = 1'b0;
        d_store = 1'b0;
        d_kind  = MD_MUL;

        unique case (opc)
            OPC_OP: begin
                d_wr = 1'b1;
                if (f7 == F7_BASE) begin
                    unique case (f3)
                        F3_ADD:  d_res = sum;
                        F3_SLL:  d_res = a_reg << opb[5:0];
                        F3_SLT:  d_res = {63'd0, $signed(a_reg) < $signed(opb)};
                        F3_XOR:  d_res = a_reg ^ opb;
                        F3_SR:   d_res = a_reg >> opb[5:0];
                        F3_OR:   d_res = a_reg | opb;
                        F3_AND:  d_res = a_reg & opb;
                        default: d_bad = 1'b1;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    d_res = dif;
                end else if (f7 == F7_ALT && f3 == F3_SR) begin
                    d_res = $unsigned($signed(a_reg) >>> opb[5:0]);
                end else if (f7 == F7_MULDIV) begin
                    d_md = 1'b1;
                    unique case (f3)
                        F3_MUL:  d_kind = MD_MUL;
                        F3_MULH: d_kind = MD_MULH;
                        F3_DIV:  d_kind = MD_DIV;
                        F3_REM:  d_kind = MD_REM;
                        default: begin
                            d_md  = 1'b0;
                            d_bad = 1'b1;
                        end
                    endcase
                end else begin
                    d_bad = 1'b1;
                end
            end
            OPC_OP32: begin
                d_wr = 1'b1;
                if (f3 == F3_ADD && f7 == F7_BASE) begin
                    d_res = sext32(sum);
                end else if (f3 == F3_ADD && f7 == F7_ALT) begin
                    d_res = sext32(dif);
                end else if (f3 == F3_MUL && f7 == F7_MULDIV) begin
                    d_md   = 1'b1;
                    d_word = 1'b1;
                end else begin
                    d_bad = 1'b1;
                end
            end
            OPC_IMM: begin
                d_wr = 1'b1;
                unique case (f3)
                    F3_ADD: d_res = sum;
                    F3_SLL: begin
                        if (f6 == F6_BASE) d_res = a_reg << opb[5:0];
                        else d_bad = 1'b1;
                    end
                    F3_SLT: d_res = {63'd0, $signed(a_reg) < $signed(opb)};
                    F3_XOR: d_res = a_reg ^ opb;
                    F3_SR: begin
                        if (f6 == F6_BASE) d_res = a_reg >> opb[5:0];
                        else if (f6 == F6_SRA) d_res = $unsigned($signed(a_reg) >>> opb[5:0]);
                        else d_bad = 1'b1;
                    end
                    F3_OR:   d_res = a_reg | opb;
                    F3_AND:  d_res = a_reg & opb;
                    default: d_bad = 1'b1;
                endcase
            end
            OPC_IMM32: begin
                d_wr = 1'b1;
                if (f3 == F3_ADD) d_res = sext32(sum);
                else d_bad = 1'b1;
            end
            OPC_STORE: begin
                ea = a_reg + imms;
                if (!f3[2]) d_store = 1'b1;
                else d_bad = 1'b1;
            end
            OPC_LOAD: begin
                d_wr = 1'b1;
                if (!f3[2]) d_load = 1'b1;
                else d_bad = 1'b1;
            end
            OPC_BRANCH: begin
                unique case (f3)
                    F3_BEQ:  take = (a_reg == b_reg);
                    F3_BNE:  take = (a_reg != b_reg);
                    F3_BLT:  take = $signed(a_reg) < $signed(b_reg);
                    F3_BGE:  take = !($signed(a_reg) < $signed(b_reg));
                    default: d_bad = 1'b1;
                endcase
                if (take) d_npc = pc_reg + immb[15:0];
            end
            OPC_JALR: begin
                if (f3 == F3_ADD) begin
                    d_wr  = 1'b1;
                    d_res = {48'd0, pc4};
                    d_npc = {sum[15:1], 1'b0};
                end else begin
                    d_bad = 1'b1;
                end
            end
            OPC_JAL: begin
                d_wr  = 1'b1;
                d_res = {48'd0, pc4};
                d_npc = pc_reg + immj[15:0];
            end
            OPC_AUIPC: begin
                d_wr  = 1'b1;
                d_res = pc_ext + immu;
            end
            OPC_LUI: begin
                d_wr  = 1'b1;
                d_res = immu;
            end
            default: d_bad = 1'b1;
        endcase

        if (d_bad) begin
            d_npc = pc4;
        end

        unique case (f3[1:0])
            2'd0:    ld_val = {{56{data_reg[7]}}, data_reg[7:0]};
            2'd1:    ld_val = {{48{data_reg[15]}}, data_reg[15:0]};
            2'd2:    ld_val = {{32{data_reg[31]}}, data_reg[31:0]};
            default: ld_val = data_reg;
        endcase
    end

    // Memory and register file port steering.
    always_comb begin
        mem_raddr = base_reg + AW'(issue_reg[2:0]);
        if (state_reg == S_MEMWR) begin
            mem_we    = 1'b1;
            mem_waddr = base_reg + AW'(issue_reg[2:0]);
            mem_wdata = b_reg[{issue_reg[2:0], 3'b000} +: 8];
        end else begin
            mem_we    = accept && (s_data.op == OP_LOAD_BYTE);
            mem_waddr = ld_ext[AW-1:0];
            mem_wdata = s_data.load_data;
        end

        rf_raddr = (state_reg == S_RS1) ? data_reg[19:15] : inst_reg[24:20];
        unique case (state_reg)
            S_START_SP: begin
                rf_we    = 1'b1;
                rf_waddr = REG_SP;
                rf_wdata = {48'd0, stack_reg};
            end
            S_START_GP: begin
                rf_we    = 1'b1;
                rf_waddr = REG_GP;
                rf_wdata = {48'd0, gp_reg};
            end
            default: begin
                rf_we    = (state_reg == S_WB) && wr_reg && (rd != 5'd0);
                rf_waddr = rd;
                rf_wdata = res_reg;
            end
        endcase

        md_start = (state_reg == S_EXEC) && d_md;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pc_reg       <= 16'd0;
            halt_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            entry_pc_reg <= 16'd0;
            end_pc_reg   <= 16'd0;
            stack_reg    <= 16'd32768;
            gp_reg       <= 16'd0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_ENTRY_PC:   entry_pc_reg <= cfg_wdata;
                    CFG_END_PC:     end_pc_reg   <= cfg_wdata;
                    CFG_STACK:      stack_reg    <= cfg_wdata;
                    CFG_GLOBAL_PTR: gp_reg       <= cfg_wdata;
                    default:        gp_reg       <= gp_reg;
                endcase
            end

            // The finish state loads the next result itself.
            if (m_valid_reg && m_ready && state_reg != S_FIN) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (s_data.op == OP_START) begin
                            pc_reg    <= entry_pc_reg;
                            halt_reg  <= 1'b0;
                            stage_reg <= '{next_pc: entry_pc_reg, reg_written: 1'b0,
                                           dest_index: 5'd0, dest_value: 64'd0,
                                           halted: 1'b0, unknown_instr: 1'b0};
                            state_reg <= S_START_SP;
                        end else if (s_data.op == OP_EXEC &&
                                     !(halt_reg || pc_reg == end_pc_reg)) begin
                            base_reg  <= pc_ext[AW-1:0];
                            n_reg     <= 4'd4;
                            issue_reg <= 4'd0;
                            cap_reg   <= 4'd0;
                            pend_reg  <= 1'b0;
                            fetch_reg <= 1'b1;
                            state_reg <= S_MEMRD;
                        end else begin
                            if (s_data.op == OP_EXEC) begin
                                halt_reg <= 1'b1;
                            end
                            stage_reg <= '{next_pc: pc_reg, reg_written: 1'b0,
                                           dest_index: 5'd0, dest_value: 64'd0,
                                           halted: halt_reg || (s_data.op == OP_EXEC),
                                           unknown_instr: 1'b0};
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_START_SP: state_reg <= S_START_GP;
                S_START_GP: state_reg <= S_FIN;
                S_MEMRD: begin
                    // Reads are pipelined: issue one byte address a cycle and
                    // capture the byte that came back from the previous one.
                    pend_reg <= (issue_reg < n_reg);
                    if (issue_reg < n_reg) begin
                        issue_reg <= issue_reg + 4'd1;
                    end
                    if (pend_reg) begin
                        data_reg[{cap_reg[2:0], 3'b000} +: 8] <= mem_rdata;
                        cap_reg <= cap_reg + 4'd1;
                        if (cap_reg + 4'd1 == n_reg) begin
                            state_reg <= fetch_reg ? S_RS1 : S_LDEXT;
                        end
                    end
                end
                S_RS1: begin
                    inst_reg  <= data_reg[31:0];
                    state_reg <= S_RS2;
                end
                S_RS2: begin
                    a_reg     <= rf_rdata;
                    state_reg <= S_RS3;
                end
                S_RS3: begin
                    b_reg     <= rf_rdata;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    res_reg   <= d_res;
                    npc_reg   <= d_npc;
                    wr_reg    <= d_wr && !d_bad;
                    bad_reg   <= d_bad;
                    word_reg  <= d_word;
                    base_reg  <= ea[AW-1:0];
                    n_reg     <= 4'd1 << f3[1:0];
                    issue_reg <= 4'd0;
                    cap_reg   <= 4'd0;
                    pend_reg  <= 1'b0;
                    fetch_reg <= 1'b0;
                    data_reg  <= 64'd0;
                    if (d_md) state_reg <= S_MULDIV;
                    else if (d_load) state_reg <= S_MEMRD;
                    else if (d_store) state_reg <= S_MEMWR;
                    else state_reg <= S_WB;
                end
                S_MULDIV: begin
                    if (md_done) begin
                        res_reg   <= word_reg ? sext32(md_result) : md_result;
                        state_reg <= S_WB;
                    end
                end
                S_LDEXT: begin
                    res_reg   <= ld_val;
                    state_reg <= S_WB;
                end
                S_MEMWR: begin
                    issue_reg <= issue_reg + 4'd1;
                    if (issue_reg + 4'd1 == n_reg) begin
                        state_reg <= S_WB;
                    end
                end
                S_WB: begin
                    pc_reg <= npc_reg;
                    if (npc_reg == end_pc_reg) begin
                        halt_reg <= 1'b1;
                    end
                    stage_reg.next_pc       <= npc_reg;
                    stage_reg.reg_written   <= wr_reg && (rd != 5'd0);
                    stage_reg.dest_index    <= (wr_reg && rd != 5'd0) ? rd : 5'd0;
                    stage_reg.dest_value    <= (wr_reg && rd != 5'd0) ? res_reg : 64'd0;
                    stage_reg.halted        <= (npc_reg == end_pc_reg);
                    stage_reg.unknown_instr <= bad_reg;
                    state_reg               <= S_FIN;
                end
                S_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= stage_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    rvs_bytemem #(
        .MEM_BYTES(MEM_BYTES)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rvs_regfile u_rf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (rf_we),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata),
        .raddr   (rf_raddr),
        .rdata   (rf_rdata)
    );

    rvs_muldiv u_md (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .kind    (d_kind),
        .op_a    (a_reg),
        .op_b    (b_reg),
        .done    (md_done),
        .result  (md_result)
    );

    `RVS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_ready, "ready after accept")
    `RVS_ASSERT_IMPL(a_no_x0_write, aclk, aresetn, m_valid && m_data.reg_written,
                     m_data.dest_index != 5'd0, "result reports write to x0")
    `RVS_ASSERT_IMPL(a_unknown_no_write, aclk, aresetn, m_valid && m_data.unknown_instr,
                     !m_data.reg_written, "unknown instruction wrote a register")
    `RVS_ASSERT_NEXT(a_fin_delivers, aclk, aresetn,
                     (state_reg == S_FIN) && (!m_valid_reg || m_ready),
                     m_valid_reg && (state_reg == S_IDLE), "finished request not delivered")

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// RV64 subset step core testbench
// Drives load, start, execute and unused-op requests with random idling on both sides,
// predicts every result in a cycle-free model of the core and compares each
// result field by field. Memory is filled ahead of each fetch or load so the
// core never reads a byte that was not written.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rvs_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int ITEM_TARGET = 1150;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_MUL  = 3'd0;
    localparam logic [2:0] F3_MULH = 3'd1;
    localparam logic [2:0] F3_DIV  = 3'd4;
    localparam logic [2:0] F3_REM  = 3'd6;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        bit   cfg;
        in_t  req;
        bit   typed;
        out_t exp;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_ENTRY_PC;
    logic [15:0] cfg_wdata = '0;

    // Architectural state of the core as the testbench sees it.
    logic [63:0] xreg [32];
    logic [15:0] pc_q;
    bit          halt_q;
    logic [7:0]  mem_img [logic [15:0]];
    logic [15:0] cfg_entry, cfg_end, cfg_stack, cfg_gp;

    out_t expected_results [$];
    row_t dir_rows [$];
    int   fail_count = 0;
    int   items_sent = 0;
    int   idle_cycles = 0;
    bit   calm = 1'b0;
    int   out_stall = 0;

    rv64_subset_instruction_step_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic logic [7:0] mem_byte(logic [15:0] a);
        return mem_img.exists(a) ? mem_img[a] : 8'h00;
    endfunction

    function automatic logic [63:0] sext32(logic [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

    function automatic logic [63:0] signed_divide(logic [63:0] a, logic [63:0] b, bit want_rem);
        logic [63:0] ma, mb, r;
        if (b == 64'd0) return want_rem ? a : '1;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        if (want_rem) begin
            r = ma % mb;
            return a[63] ? -r : r;
        end
        r = ma / mb;
        return (a[63] != b[63]) ? -r : r;
    endfunction

    function automatic out_t execute_at_pc();
        out_t o;
        logic [31:0] inst;
        logic [6:0] opc, f7;
        logic [5:0] f6;
        logic [4:0] rd;
        logic [2:0] f3;
        logic [63:0] a, b, immi, imms, immb, immj, immu, res, nxt;
        logic [127:0] prod;
        logic [15:0] addr;
        bit wr, bad, take;
        int n;
        o = '0;
        for (int i = 0; i < 4; i++) inst[8*i +: 8] = mem_byte(pc_q + 16'(i));
        opc = inst[6:0]; rd = inst[11:7]; f3 = inst[14:12];
        f7 = inst[31:25]; f6 = inst[31:26];
        a = xreg[inst[19:15]];
        b = xreg[inst[24:20]];
        immi = {{52{inst[31]}}, inst[31:20]};
        imms = {{52{inst[31]}}, inst[31:25], inst[11:7]};
        immb = {{51{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
        immj = {{43{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
        immu = {{32{inst[31]}}, inst[31:12], 12'h000};
        nxt = 64'(pc_q) + 64'd4;
        res = '0; wr = 1'b0; bad = 1'b0; take = 1'b0;
        case (opc)
            OPC_OP: begin
                wr = 1'b1;
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD: res = a + b;
                        F3_SLL: res = a << b[5:0];
                        F3_SLT: res = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
                        F3_XOR: res = a ^ b;
                        F3_SR:  res = a >> b[5:0];
                        F3_OR:  res = a | b;
                        F3_AND: res = a & b;
                        default: bad = 1'b1;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_ADD) res = a - b;
                else if (f7 == F7_ALT && f3 == F3_SR) res = $signed(a) >>> b[5:0];
                else if (f7 == F7_MULDIV && f3 == F3_MUL) res = a * b;
                else if (f7 == F7_MULDIV && f3 == F3_MULH) begin
                    prod = {{64{a[63]}}, a} * {{64{b[63]}}, b};
                    res = prod[127:64];
                end
                else if (f7 == F7_MULDIV && f3 == F3_DIV) res = signed_divide(a, b, 1'b0);
                else if (f7 == F7_MULDIV && f3 == F3_REM) res = signed_divide(a, b, 1'b1);
                else bad = 1'b1;
            end
            OPC_OP32: begin
                wr = 1'b1;
                if (f3 == F3_ADD && f7 == F7_BASE) res = sext32(a + b);
                else if (f3 == F3_ADD && f7 == F7_ALT) res = sext32(a - b);
                else if (f3 == F3_MUL && f7 == F7_MULDIV) res = sext32(a * b);
                else bad = 1'b1;
            end
            OPC_IMM: begin
                wr = 1'b1;
                case (f3)
                    F3_ADD: res = a + immi;
                    F3_SLL: if (f6 == F6_BASE) res = a << immi[5:0]; else bad = 1'b1;
                    F3_SLT: res = ($signed(a) < $signed(immi)) ? 64'd1 : 64'd0;
                    F3_XOR: res = a ^ immi;
                    F3_SR: begin
                        if (f6 == F6_BASE) res = a >> immi[5:0];
                        else if (f6 == F6_SRA) res = $signed(a) >>> immi[5:0];
                        else bad = 1'b1;
                    end
                    F3_OR:  res = a | immi;
                    F3_AND: res = a & immi;
                    default: bad = 1'b1;
                endcase
            end
            OPC_IMM32: begin
                wr = 1'b1;
                if (f3 == F3_ADD) res = sext32(a + immi); else bad = 1'b1;
            end
            OPC_STORE: begin
                if (f3 < 3'd4) begin
                    addr = 16'(a + imms);
                    for (int i = 0; i < (1 << f3); i++) mem_img[addr + 16'(i)] = b[8*i +: 8];
                end else bad = 1'b1;
            end
            OPC_LOAD: begin
                wr = 1'b1;
                if (f3 < 3'd4) begin
                    n = 1 << f3;
                    addr = 16'(a + immi);
                    for (int i = 0; i < n; i++) res[8*i +: 8] = mem_byte(addr + 16'(i));
                    case (n)
                        1: res = {{56{res[7]}}, res[7:0]};
                        2: res = {{48{res[15]}}, res[15:0]};
                        4: res = sext32(res);
                        default: ;
                    endcase
                end else bad = 1'b1;
            end
            OPC_BRANCH: begin
                case (f3)
                    F3_BEQ: take = (a == b);
                    F3_BNE: take = (a != b);
                    F3_BLT: take = $signed(a) < $signed(b);
                    F3_BGE: take = !($signed(a) < $signed(b));
                    default: bad = 1'b1;
                endcase
                if (take) nxt = 64'(pc_q) + immb;
            end
            OPC_JALR: begin
                if (f3 == 3'd0) begin
                    wr = 1'b1;
                    res = {48'h0, nxt[15:0]};
                    nxt = (a + immi) & ~64'd1;
                end else bad = 1'b1;
            end
            OPC_JAL: begin
                wr = 1'b1;
                res = {48'h0, nxt[15:0]};
                nxt = 64'(pc_q) + immj;
            end
            OPC_AUIPC: begin
                wr = 1'b1;
                res = 64'(pc_q) + immu;
            end
            OPC_LUI: begin
                wr = 1'b1;
                res = immu;
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            wr = 1'b0;
            nxt = 64'(pc_q) + 64'd4;
        end
        if (wr && rd != 5'd0) begin
            xreg[rd] = res;
            o.reg_written = 1'b1;
            o.dest_index = rd;
            o.dest_value = res;
        end
        pc_q = nxt[15:0];
        if (pc_q == cfg_end) halt_q = 1'b1;
        o.next_pc = pc_q;
        o.halted = halt_q;
        o.unknown_instr = bad;
        return o;
    endfunction

    function automatic out_t predict_step(in_t r);
        out_t o;
        o = '0;
        case (r.op)
            OP_LOAD_BYTE: mem_img[r.load_address] = r.load_data;
            OP_START: begin
                pc_q = cfg_entry;
                xreg[2] = 64'(cfg_stack);
                xreg[3] = 64'(cfg_gp);
                halt_q = 1'b0;
            end
            OP_EXEC: begin
                if (halt_q || pc_q == cfg_end) halt_q = 1'b1;
                else return execute_at_pc();
            end
            default: ;
        endcase
        o.next_pc = pc_q;
        o.halted = halt_q;
        return o;
    endfunction

    // ---------------- instruction encoders ----------------
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(logic [6:0] opc, logic [4:0] rd, logic [2:0] f3,
                                          logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                          logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                          logic [12:0] imm);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
    endfunction

    // Mostly well-formed instructions, with near misses and raw words mixed in.
    function automatic logic [31:0] random_instr();
        logic [4:0] rd, rs1, rs2;
        logic [2:0] f3;
        logic [11:0] imm;
        logic [6:0] f7;
        int kind;
        rd = pick_reg(); rs1 = pick_reg(); rs2 = pick_reg();
        f3 = 3'($urandom);
        imm = 12'($urandom);
        kind = $urandom_range(0, 99);
        f7 = ($urandom_range(0, 3) == 0) ? F7_MULDIV : (($urandom_range(0, 1) != 0) ? F7_ALT : F7_BASE);
        if ($urandom_range(0, 15) == 0) f7 = 7'($urandom);
        if (kind < 18) return enc_r(f7, rs2, rs1, f3, rd, OPC_OP);
        if (kind < 24) return enc_r(f7, rs2, rs1, ($urandom_range(0, 3) != 0) ? F3_ADD : f3, rd, OPC_OP32);
        if (kind < 42) begin
            if (f3 == F3_SLL || f3 == F3_SR)
                imm[11:6] = ($urandom_range(0, 7) == 0) ? 6'($urandom)
                          : (($urandom_range(0, 1) != 0) ? 6'(F6_SRA) : 6'(F6_BASE));
            return enc_i(OPC_IMM, rd, f3, rs1, imm);
        end
        if (kind < 48) return enc_i(OPC_IMM32, rd, ($urandom_range(0, 3) != 0) ? F3_ADD : f3, rs1, imm);
        if (kind < 56) return enc_s(($urandom_range(0, 5) != 0) ? {1'b0, f3[1:0]} : f3, rs1, rs2, imm);
        if (kind < 66) return enc_i(OPC_LOAD, rd, ($urandom_range(0, 5) != 0) ? {1'b0, f3[1:0]} : f3,
                                    rs1, imm);
        if (kind < 76) return enc_b(f3, rs1, rs2, 13'($signed($urandom_range(0, 64)) - 32) << 1);
        if (kind < 80) return enc_j(rd, 21'($signed($urandom_range(0, 64)) - 32) << 1);
        if (kind < 84) return enc_i(OPC_JALR, rd, ($urandom_range(0, 3) != 0) ? 3'd0 : f3, rs1, imm);
        if (kind < 89) return {20'($urandom), rd, OPC_AUIPC};
        if (kind < 95) return {20'($urandom), rd, OPC_LUI};
        return $urandom;
    endfunction

    // ---------------- request side ----------------
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic out_t mk_out(logic [15:0] pc, bit wr, logic [4:0] idx, logic [63:0] val,
                                    bit halted, bit unk);
        out_t o;
        o.next_pc = pc; o.reg_written = wr; o.dest_index = idx;
        o.dest_value = val; o.halted = halted; o.unknown_instr = unk;
        return o;
    endfunction

    function automatic in_t mk_req(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
        in_t r;
        r.op = op; r.load_address = addr; r.load_data = data;
        return r;
    endfunction

    task automatic send_request(in_t r, bit typed = 1'b0, out_t typed_exp = '0);
        out_t pred;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pred = predict_step(r);
        expected_results.push_back(typed ? typed_exp : pred);
        if (r.op != OP_UNUSED) items_sent++;
    endtask

    // Writes the fetch word, and the bytes a load would read, where not yet in memory, before the step.
    task automatic send_exec();
        logic [31:0] inst;
        logic [15:0] addr;
        bit missing;
        if (!(halt_q || pc_q == cfg_end)) begin
            missing = 1'b0;
            for (int i = 0; i < 4; i++) if (!mem_img.exists(pc_q + 16'(i))) missing = 1'b1;
            if (missing) begin
                inst = random_instr();
                for (int i = 0; i < 4; i++)
                    send_request(mk_req(OP_LOAD_BYTE, pc_q + 16'(i), inst[8*i +: 8]));
            end
            for (int i = 0; i < 4; i++) inst[8*i +: 8] = mem_img[pc_q + 16'(i)];
            if (inst[6:0] == OPC_LOAD && inst[14:12] < 3'd4) begin
                addr = 16'(xreg[inst[19:15]] + {{52{inst[31]}}, inst[31:20]});
                for (int i = 0; i < (1 << inst[14:12]); i++)
                    if (!mem_img.exists(addr + 16'(i)))
                        send_request(mk_req(OP_LOAD_BYTE, addr + 16'(i), 8'($urandom)));
            end
        end
        send_request(mk_req(OP_EXEC, 16'($urandom), 8'($urandom)));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ENTRY_PC: cfg_entry = val;
            CFG_END_PC:   cfg_end = val;
            CFG_STACK:    cfg_stack = val;
            default:      cfg_gp = val;
        endcase
        @(posedge aclk);
    endtask

    task automatic write_all_regs(logic [15:0] e, logic [15:0] t, logic [15:0] sp, logic [15:0] gp);
        write_reg(CFG_ENTRY_PC, e);
        write_reg(CFG_END_PC, t);
        write_reg(CFG_STACK, sp);
        write_reg(CFG_GLOBAL_PTR, gp);
    endtask

    task automatic add_row(in_t r, bit typed, out_t exp);
        row_t row;
        row.cfg = 1'b0; row.req = r; row.typed = typed; row.exp = exp;
        dir_rows.push_back(row);
    endtask

    task automatic add_word(logic [15:0] addr, logic [31:0] w);
        for (int i = 0; i < 4; i++)
            add_row(mk_req(OP_LOAD_BYTE, addr + 16'(i), w[8*i +: 8]), 1'b1,
                    mk_out(16'h0000, 1'b0, 5'd0, 64'd0, 1'b1, 1'b0));
    endtask

    task automatic build_directed();
        row_t cfg_row;
        // Right after reset pc equals end_pc, so the first step halts.
        add_row(mk_req(OP_EXEC, 16'h0000, 8'h00), 1'b1, mk_out(16'h0000, 1'b0, 5'd0, 64'd0, 1'b1, 1'b0));
        add_row(mk_req(OP_UNUSED, 16'hFFFF, 8'hFF), 1'b1, mk_out(16'h0000, 1'b0, 5'd0, 64'd0, 1'b1, 1'b0));
        cfg_row = '{cfg: 1'b1, req: '0, typed: 1'b0, exp: '0};
        dir_rows.push_back(cfg_row);
        add_word(16'h0100, {20'h80000, 5'd5, OPC_LUI});
        add_word(16'h0104, enc_r(F7_MULDIV, 5'd0, 5'd5, F3_DIV, 5'd6, OPC_OP));
        add_word(16'h0108, enc_r(F7_MULDIV, 5'd0, 5'd5, F3_REM, 5'd7, OPC_OP));
        add_word(16'h010C, enc_r(F7_BASE, 5'd2, 5'd1, F3_SLTU, 5'd8, OPC_OP));
        add_row(mk_req(OP_START, 16'h0000, 8'h00), 1'b0, '0);
        add_row(mk_req(OP_EXEC, 16'h0000, 8'h00), 1'b1,
                mk_out(16'h0104, 1'b1, 5'd5, 64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0));
        // Division by zero gives all ones, remainder by zero the dividend.
        add_row(mk_req(OP_EXEC, 16'h0000, 8'h00), 1'b1,
                mk_out(16'h0108, 1'b1, 5'd6, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0));
        add_row(mk_req(OP_EXEC, 16'h0000, 8'h00), 1'b1,
                mk_out(16'h010C, 1'b1, 5'd7, 64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0));
        add_row(mk_req(OP_EXEC, 16'h0000, 8'h00), 1'b1,
                mk_out(16'h0110, 1'b0, 5'd0, 64'd0, 1'b1, 1'b1));
        add_row(mk_req(OP_EXEC, 16'h0000, 8'h00), 1'b1,
                mk_out(16'h0110, 1'b0, 5'd0, 64'd0, 1'b1, 1'b0));
    endtask

    task automatic run_phase(int phase);
        logic [15:0] e, t;
        int steps, r;
        wait_idle();
        calm = ($urandom_range(0, 4) == 0);
        if (phase % 4 == 0) begin
            if (phase % 8 == 0) write_all_regs(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
            else write_all_regs(16'hFFFC, 16'h0000, 16'h0000, 16'hFFFF);
        end else begin
            e = ($urandom_range(0, 7) == 0) ? 16'($urandom) : {14'($urandom), 2'b00};
            t = ($urandom_range(0, 3) == 0) ? 16'($urandom) : e + 16'($urandom_range(1, 40) * 4);
            write_all_regs(e, t, 16'($urandom), 16'($urandom));
        end
        send_request(mk_req(OP_START, 16'($urandom), 8'($urandom)));
        steps = $urandom_range(40, 120);
        for (int k = 0; k < steps && items_sent < ITEM_TARGET; k++) begin
            r = $urandom_range(0, 99);
            if (r < 82) send_exec();
            else if (r < 90) send_request(mk_req(OP_LOAD_BYTE, 16'($urandom), 8'($urandom)));
            else if (r < 95) send_request(mk_req(OP_START, 16'($urandom), 8'($urandom)));
            else send_request(mk_req(OP_UNUSED, 16'($urandom), 8'($urandom)));
        end
    endtask

    // ---------------- result side ----------------
    always @(posedge aclk) begin
        if (out_stall > 0) begin
            m_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end else if (calm || $urandom_range(0, 99) < 65) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            out_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        end
    end

    task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
        if (exp !== act) begin
            $error("%s: expected %h, got %h", name, exp, act);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        out_t exp;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request pending: %p", m_data);
                fail_count++;
            end else begin
                exp = expected_results.pop_front();
                check_field("next_pc", 64'(exp.next_pc), 64'(m_data.next_pc));
                check_field("reg_written", 64'(exp.reg_written), 64'(m_data.reg_written));
                check_field("dest_index", 64'(exp.dest_index), 64'(m_data.dest_index));
                check_field("dest_value", exp.dest_value, m_data.dest_value);
                check_field("halted", 64'(exp.halted), 64'(m_data.halted));
                check_field("unknown_instr", 64'(exp.unknown_instr), 64'(m_data.unknown_instr));
            end
        end
    end

    // Ends a hung run: counts cycles in which neither channel moves.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int phase;
        for (int i = 0; i < 32; i++) xreg[i] = '0;
        pc_q = '0; halt_q = 1'b0;
        cfg_entry = 16'h0000; cfg_end = 16'h0000; cfg_stack = 16'h8000; cfg_gp = 16'h0000;
        build_directed();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg) begin
                wait_idle();
                write_all_regs(16'h0100, 16'h0110, 16'hFFFF, 16'h1234);
            end else begin
                send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].exp);
            end
        end
        phase = 1;
        while (items_sent < ITEM_TARGET) begin
            run_phase(phase);
            phase++;
        end
        wait_idle();
        repeat (80) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            if (expected_results.size() != 0)
                $error("%0d results never arrived", expected_results.size());
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
